// ===== rtl/core/grid_region_flood_fill_core_macros.svh =====
// Assertion macros for the checker file of the flood fill core
`ifndef GRID_REGION_FLOOD_FILL_CORE_MACROS_SVH
`define GRID_REGION_FLOOD_FILL_CORE_MACROS_SVH

// Property checked on every clock edge outside reset
`define GRF_ASSERT_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("flood fill core assertion failed");

// Property checked on every clock edge, reset included
`define GRF_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("flood fill core assertion failed");

`endif

// ===== rtl/core/grf_pkg.sv =====
// Package: grid sizes, cell and stack types, command codes and helper functions
package grf_pkg;

   // grid geometry
   localparam int GRID_WIDTH  = 16;
   localparam int GRID_HEIGHT = 16;
   localparam int CELL_COUNT  = GRID_WIDTH * GRID_HEIGHT;

   localparam int COL_W = (GRID_WIDTH > 2) ? $clog2(GRID_WIDTH) : 1;
   localparam int ROW_W = (GRID_HEIGHT > 2) ? $clog2(GRID_HEIGHT) : 1;
   localparam int IDX_W = $clog2(CELL_COUNT);
   localparam int SP_W  = $clog2(CELL_COUNT + 1);
   localparam int CNT_W = $clog2(CELL_COUNT + 1);

   // word field widths
   localparam int CMD_W    = 3;
   localparam int FCOORD_W = 4;
   localparam int COLOR_W  = 4;
   localparam int TOTAL_W  = 9;
   localparam int TOTAL_MAX = (1 << TOTAL_W) - 1;

   // command codes
   localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_FILL   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DELETE = 3'd4;

   // neighbour offsets: up, left, right, down
   localparam int NB_DCOL [4] = '{0, -1, 1, 0};
   localparam int NB_DROW [4] = '{-1, 0, 0, 1};

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } coord_type;

   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic               mark;
   } cell_type;

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      cell_type         wr_data;
   } cell_req_type;

   typedef struct packed {
      logic      push;
      logic      pop;
      coord_type wr_data;
   } stk_req_type;

   typedef struct packed {
      logic      ok;
      coord_type pos;
   } nb_type;

   // linear cell address of a coordinate
   function automatic logic [IDX_W-1:0] cell_addr(coord_type c);
      return IDX_W'(int'(c.row) * GRID_WIDTH + int'(c.col));
   endfunction

   // neighbour k of a cell, with its in-grid flag
   function automatic nb_type nb_step(coord_type cur, logic [1:0] k);
      int     nc;
      int     nr;
      nb_type res;
      nc = int'(cur.col) + NB_DCOL[k];
      nr = int'(cur.row) + NB_DROW[k];
      res.ok = (nc >= 0) && (nc < GRID_WIDTH) && (nr >= 0) && (nr < GRID_HEIGHT);
      res.pos.col = COL_W'(nc);
      res.pos.row = ROW_W'(nr);
      return res;
   endfunction

   // marked count clipped to the result field
   function automatic logic [TOTAL_W-1:0] sat_total(logic [CNT_W-1:0] cnt);
      if (int'(cnt) > TOTAL_MAX) begin
         return TOTAL_W'(TOTAL_MAX);
      end
      return TOTAL_W'(cnt);
   endfunction

endpackage

// ===== rtl/core/grf_if.sv =====
// Request and response channel interfaces of the flood fill core
interface grf_req_if;
   import grf_pkg::*;

   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [FCOORD_W-1:0] col;
   logic [FCOORD_W-1:0] row;
   logic [COLOR_W-1:0]  color_in;
   logic                mark_in;

   modport source (output valid, command, col, row, color_in, mark_in, input ready);
   modport sink (input valid, command, col, row, color_in, mark_in, output ready);
endinterface

interface grf_rsp_if;
   import grf_pkg::*;

   logic               valid;
   logic               ready;
   logic [TOTAL_W-1:0] marked_total;
   logic [COLOR_W-1:0] color_out;

   modport source (output valid, marked_total, color_out, input ready);
   modport sink (input valid, marked_total, color_out, output ready);
endinterface

// ===== rtl/core/grf_cell_store.sv =====
// Cell memory: colour and mark per cell, one write and one registered read a cycle
module grf_cell_store (
   input  logic                  clock,
   input  grf_pkg::cell_req_type req_in,
   output grf_pkg::cell_type     rd_data
);
   import grf_pkg::*;

   cell_type mem_ff [CELL_COUNT];
   cell_type rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (req_in.wr_en) begin
         mem_ff[req_in.wr_addr] <= req_in.wr_data;
      end
      if (req_in.rd_en) begin
         rd_data_ff <= mem_ff[req_in.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/grf_fill_stack.sv =====
// Fill stack: coordinates of cells still to visit, with its stack pointer
module grf_fill_stack (
   input  logic                 clock,
   input  logic                 reset,
   input  grf_pkg::stk_req_type req_in,
   output grf_pkg::coord_type   rd_data,
   output logic                 empty
);
   import grf_pkg::*;

   coord_type       mem_ff [CELL_COUNT];
   coord_type       rd_data_ff;
   logic [SP_W-1:0] sp_ff;
   logic [SP_W-1:0] sp_in;
   logic [SP_W-1:0] sp_dec;

   assign sp_dec = sp_ff - SP_W'(1);

   // pointer update
   always_comb begin
      sp_in = sp_ff;
      if (req_in.push) begin
         sp_in = sp_ff + SP_W'(1);
      end else if (req_in.pop) begin
         sp_in = sp_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
      end else begin
         sp_ff <= sp_in;
      end
   end

   // storage: push writes at the pointer, pop reads the top word
   always_ff @(posedge clock) begin
      if (req_in.push) begin
         mem_ff[sp_ff[IDX_W-1:0]] <= req_in.wr_data;
      end
      if (req_in.pop) begin
         rd_data_ff <= mem_ff[sp_dec[IDX_W-1:0]];
      end
   end

   assign rd_data = rd_data_ff;
   assign empty   = (sp_ff == '0);

endmodule

// ===== rtl/core/grid_region_flood_fill_core.sv =====
// Fill query: one pop, then probes of up to four in-grid neighbours (a read, then a
//   check) through the single cell memory read port, for each popped cell.
// Clear marks and delete marked: one cell memory sweep. One command at a time;
//   req ready only when idle.
// Reset: synchronous; a clearing pass then empties every cell, and no word is
//   taken until it ends.
module grid_region_flood_fill_core (
   input logic       clock,
   input logic       reset,
   grf_req_if.sink   req_chan,
   grf_rsp_if.source rsp_chan
);
   import grf_pkg::*;

   // sequencer states
   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] ST_INIT  = 4'd0;
   localparam logic [ST_W-1:0] ST_IDLE  = 4'd1;
   localparam logic [ST_W-1:0] ST_WR    = 4'd2;
   localparam logic [ST_W-1:0] ST_RD    = 4'd3;
   localparam logic [ST_W-1:0] ST_F0    = 4'd4;
   localparam logic [ST_W-1:0] ST_POP   = 4'd5;
   localparam logic [ST_W-1:0] ST_NB    = 4'd6;
   localparam logic [ST_W-1:0] ST_NBCHK = 4'd7;
   localparam logic [ST_W-1:0] ST_SWEEP = 4'd8;
   localparam logic [ST_W-1:0] ST_OUT   = 4'd9;

   logic [ST_W-1:0]    state_ff, state_in;
   logic [SP_W-1:0]    sw_ff, sw_in;
   logic               pend_ff, pend_in;
   logic [IDX_W-1:0]   pend_addr_ff, pend_addr_in;
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   coord_type          pos_ff, pos_in;
   logic [COLOR_W-1:0] color_in_ff, color_in_in;
   logic               mark_in_ff, mark_in_in;
   logic [COLOR_W-1:0] fill_color_ff, fill_color_in;
   logic [1:0]         k_ff, k_in;
   coord_type          nb_pos_ff, nb_pos_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [TOTAL_W-1:0] res_total_ff, res_total_in;
   logic [COLOR_W-1:0] res_color_ff, res_color_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;
   logic [COLOR_W-1:0] rsp_color_ff, rsp_color_in;

   cell_req_type cell_req;
   cell_type     cell_rd;
   stk_req_type  stk_req;
   coord_type    stk_top;
   logic         stk_empty;

   logic      accept;
   logic      in_ok;
   coord_type in_pos;
   nb_type    nb;
   logic      sw_more;

   grf_cell_store u_cells (
      .clock   (clock),
      .req_in  (cell_req),
      .rd_data (cell_rd)
   );

   grf_fill_stack u_stack (
      .clock   (clock),
      .reset   (reset),
      .req_in  (stk_req),
      .rd_data (stk_top),
      .empty   (stk_empty)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept = req_chan.valid && req_chan.ready;

   // incoming address
   assign in_ok = (int'(req_chan.col) < GRID_WIDTH) && (int'(req_chan.row) < GRID_HEIGHT);
   assign in_pos.col = COL_W'(req_chan.col);
   assign in_pos.row = ROW_W'(req_chan.row);

   assign nb      = nb_step(stk_top, k_ff);
   assign sw_more = (sw_ff != SP_W'(CELL_COUNT));

   // sequencer
   always_comb begin
      state_in      = state_ff;
      sw_in         = sw_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      cmd_in        = cmd_ff;
      pos_in        = pos_ff;
      color_in_in   = color_in_ff;
      mark_in_in    = mark_in_ff;
      fill_color_in = fill_color_ff;
      k_in          = k_ff;
      nb_pos_in     = nb_pos_ff;
      count_in      = count_ff;
      res_total_in  = res_total_ff;
      res_color_in  = res_color_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_total_in  = rsp_total_ff;
      rsp_color_in  = rsp_color_ff;
      cell_req      = '0;
      stk_req       = '0;

      case (state_ff)
         // empty every cell after reset
         ST_INIT: begin
            cell_req.wr_en   = 1'b1;
            cell_req.wr_addr = sw_ff[IDX_W-1:0];
            cell_req.wr_data = '0;
            sw_in = sw_ff + SP_W'(1);
            if (sw_ff == SP_W'(CELL_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end

         // take a word and start the read of its cell
         ST_IDLE: begin
            if (accept) begin
               cmd_in           = req_chan.command;
               pos_in           = in_pos;
               color_in_in      = req_chan.color_in;
               mark_in_in       = req_chan.mark_in;
               res_total_in     = '0;
               res_color_in     = '0;
               sw_in            = '0;
               cell_req.rd_en   = in_ok;
               cell_req.rd_addr = cell_addr(in_pos);
               case (req_chan.command)
                  CMD_WRITE:  state_in = in_ok ? ST_WR : ST_OUT;
                  CMD_READ:   state_in = in_ok ? ST_RD : ST_OUT;
                  CMD_FILL: begin
                     if (in_ok) begin
                        state_in = ST_F0;
                     end else begin
                        res_total_in = sat_total(count_ff);
                        state_in     = ST_OUT;
                     end
                  end
                  CMD_CLEAR:  state_in = ST_SWEEP;
                  CMD_DELETE: state_in = ST_SWEEP;
                  default:    state_in = ST_OUT;
               endcase
            end
         end

         // write: keep the mark count in step with the old mark
         ST_WR: begin
            if (cell_rd.mark && !mark_in_ff) begin
               count_in = count_ff - CNT_W'(1);
            end else if (!cell_rd.mark && mark_in_ff) begin
               count_in = count_ff + CNT_W'(1);
            end
            cell_req.wr_en         = 1'b1;
            cell_req.wr_addr       = cell_addr(pos_ff);
            cell_req.wr_data.color = color_in_ff;
            cell_req.wr_data.mark  = mark_in_ff;
            state_in = ST_OUT;
         end

         ST_RD: begin
            res_color_in = cell_rd.color;
            state_in     = ST_OUT;
         end

         // fill start cell: empty gives 0, marked leaves the stack empty
         ST_F0: begin
            fill_color_in = cell_rd.color;
            if (cell_rd.color == '0) begin
               res_total_in = '0;
               state_in     = ST_OUT;
            end else begin
               if (!cell_rd.mark) begin
                  cell_req.wr_en         = 1'b1;
                  cell_req.wr_addr       = cell_addr(pos_ff);
                  cell_req.wr_data.color = cell_rd.color;
                  cell_req.wr_data.mark  = 1'b1;
                  count_in               = count_ff + CNT_W'(1);
                  stk_req.push           = 1'b1;
                  stk_req.wr_data        = pos_ff;
               end
               state_in = ST_POP;
            end
         end

         ST_POP: begin
            if (stk_empty) begin
               res_total_in = sat_total(count_ff);
               state_in     = ST_OUT;
            end else begin
               stk_req.pop = 1'b1;
               k_in        = '0;
               state_in    = ST_NB;
            end
         end

         // probe neighbour k of the popped cell
         ST_NB: begin
            if (nb.ok) begin
               cell_req.rd_en   = 1'b1;
               cell_req.rd_addr = cell_addr(nb.pos);
               nb_pos_in        = nb.pos;
               state_in         = ST_NBCHK;
            end else if (k_ff == 2'd3) begin
               state_in = ST_POP;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end

         // mark and push a matching unmarked neighbour
         ST_NBCHK: begin
            if (!cell_rd.mark && (cell_rd.color == fill_color_ff)) begin
               cell_req.wr_en         = 1'b1;
               cell_req.wr_addr       = cell_addr(nb_pos_ff);
               cell_req.wr_data.color = fill_color_ff;
               cell_req.wr_data.mark  = 1'b1;
               count_in               = count_ff + CNT_W'(1);
               stk_req.push           = 1'b1;
               stk_req.wr_data        = nb_pos_ff;
            end
            if (k_ff == 2'd3) begin
               state_in = ST_POP;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = ST_NB;
            end
         end

         // read-modify-write sweep for clear marks and delete marked
         ST_SWEEP: begin
            if (sw_more) begin
               cell_req.rd_en   = 1'b1;
               cell_req.rd_addr = sw_ff[IDX_W-1:0];
               sw_in            = sw_ff + SP_W'(1);
               pend_in          = 1'b1;
               pend_addr_in     = sw_ff[IDX_W-1:0];
            end
            if (pend_ff) begin
               cell_req.wr_en         = 1'b1;
               cell_req.wr_addr       = pend_addr_ff;
               cell_req.wr_data.color = (cmd_ff == CMD_DELETE && cell_rd.mark) ?
                                        '0 : cell_rd.color;
               cell_req.wr_data.mark  = 1'b0;
            end
            if (!sw_more && !pend_ff) begin
               count_in = '0;
               state_in = ST_OUT;
            end
         end

         // hand the result to the output register once it is free
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_total_in = res_total_ff;
               rsp_color_in = res_color_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sw_ff        <= '0;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sw_ff        <= sw_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_addr_ff  <= pend_addr_in;
      cmd_ff        <= cmd_in;
      pos_ff        <= pos_in;
      color_in_ff   <= color_in_in;
      mark_in_ff    <= mark_in_in;
      fill_color_ff <= fill_color_in;
      k_ff          <= k_in;
      nb_pos_ff     <= nb_pos_in;
      res_total_ff  <= res_total_in;
      res_color_ff  <= res_color_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_color_ff  <= rsp_color_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.marked_total = rsp_total_ff;
   assign rsp_chan.color_out    = rsp_color_ff;

endmodule

// ===== rtl/core/grf_checker.sv =====
// Port-level checker for the flood fill core, with its bind statement
`include "grid_region_flood_fill_core_macros.svh"

module grf_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [grf_pkg::TOTAL_W-1:0] marked_total,
   input logic [grf_pkg::COLOR_W-1:0] color_out
);
   import grf_pkg::*;

   // clearing pass keeps the request side closed right after reset
   `GRF_ASSERT_ALWAYS(a_busy_after_reset, clock, reset |=> !req_ready)

   // every accepted word makes the block busy and drops req ready
   `GRF_ASSERT_RST(a_busy_after_accept, clock, reset, (req_valid && req_ready) |=> !req_ready)

   // a word never carries both a read colour and a fill total
   `GRF_ASSERT_RST(a_one_field, clock, reset, rsp_valid |-> (marked_total == '0 || color_out == '0))

   // a stalled response word holds
   `GRF_ASSERT_RST(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(marked_total) && $stable(color_out)))

endmodule

bind grid_region_flood_fill_core grf_checker u_grf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .marked_total (rsp_chan.marked_total),
   .color_out    (rsp_chan.color_out)
);
